// ===== src/dhm_pkg.sv =====
package dhm_pkg;

    // fixed field widths
    localparam int DATA_W   = 32;
    localparam int EXP_BITS = 32;
    localparam int CNT_W    = $clog2(EXP_BITS);
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP  = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL_ACC,
        ST_MUL_SQR,
        ST_DONE
    } t_state;

    // which product the multiplier is working on
    typedef enum logic [1:0] {
        MUL_RED,
        MUL_ACC,
        MUL_SQR
    } t_mul_sel;

    // controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     exp_shift;
        logic     out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic mul_done;
        logic exp_zero;
        logic exp_lsb;
        logic out_free;
    } t_dp_status;

endpackage

// ===== src/dhm_modmul.sv =====
module dhm_modmul
    import dhm_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [WIDTH-1:0]    i_a,
    input  logic [EXP_BITS-1:0] i_b,
    input  logic [WIDTH-1:0]    i_m,
    output logic                o_done,
    output logic [WIDTH-1:0]    o_product
);

    logic                r_busy;
    logic                r_done;
    logic                r_phase;
    logic [CNT_W-1:0]    r_cnt;
    logic [WIDTH-1:0]    r_a;
    logic [EXP_BITS-1:0] r_b;
    logic [WIDTH-1:0]    r_r;

    logic [WIDTH:0]      n_dbl;
    logic [WIDTH:0]      n_sum;
    logic [WIDTH:0]      n_pre;
    logic [WIDTH:0]      n_red;

    // one doubling or one conditional add per cycle, then a single compare-subtract
    always_comb begin
        n_dbl = {r_r, 1'b0};
        n_sum = {1'b0, r_r} + {1'b0, r_a};
        if (r_phase) begin
            n_pre = r_b[EXP_BITS-1] ? n_sum : {1'b0, r_r};
        end else begin
            n_pre = n_dbl;
        end
        if (n_pre >= {1'b0, i_m}) begin
            n_red = n_pre - {1'b0, i_m};
        end else begin
            n_red = n_pre;
        end
    end

    // loop control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= CNT_W'(EXP_BITS - 1);
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
            end
        end
    end

    // operand and partial remainder registers, msb-first over b
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_r <= '0;
        end else if (r_busy) begin
            r_r <= n_red[WIDTH-1:0];
            if (r_phase) begin
                r_b <= r_b << 1;
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_r;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiplier started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("multiplier done held for more than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("multiplier done while still busy");

endmodule

// ===== src/dhm_datapath.sv =====
module dhm_datapath
    import dhm_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_ctl,
    output t_dp_status           o_status,
    input  logic                 i_cmd,
    input  logic [DATA_W-1:0]    i_peer_value,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [DATA_W-1:0]    o_result
);

    logic [DATA_W-1:0]   r_modulus;
    logic [DATA_W-1:0]   r_generator;
    logic [EXP_BITS-1:0] r_priv_exp;
    logic [WIDTH-1:0]    r_base;
    logic [WIDTH-1:0]    r_acc;
    logic [EXP_BITS-1:0] r_exp;
    t_mul_sel            r_dest;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_result;

    logic [WIDTH-1:0]    w_m;
    logic                w_mod_small;
    logic                w_out_free;
    logic [WIDTH-1:0]    w_mul_a;
    logic [EXP_BITS-1:0] w_mul_b;
    logic                w_mul_done;
    logic [WIDTH-1:0]    w_mul_prod;

    assign w_m         = r_modulus[WIDTH-1:0];
    assign w_mod_small = (w_m >> 1) == '0;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= DATA_W'(2);
            r_generator <= DATA_W'(2);
            r_priv_exp  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODULUS:   r_modulus   <= i_cfg_data;
                CFG_GENERATOR: r_generator <= i_cfg_data;
                CFG_PRIV_EXP:  r_priv_exp  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // multiplier operand select
    always_comb begin
        case (i_ctl.mul_sel)
            MUL_RED: begin
                w_mul_a = WIDTH'(1);
                w_mul_b = i_cmd ? i_peer_value : r_generator;
            end
            MUL_ACC: begin
                w_mul_a = r_acc;
                w_mul_b = EXP_BITS'(r_base);
            end
            MUL_SQR: begin
                w_mul_a = r_base;
                w_mul_b = EXP_BITS'(r_base);
            end
            default: begin
                w_mul_a = r_base;
                w_mul_b = EXP_BITS'(r_base);
            end
        endcase
    end

    dhm_modmul #(
        .WIDTH (WIDTH)
    ) u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_ctl.mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .i_m       (w_m),
        .o_done    (w_mul_done),
        .o_product (w_mul_prod)
    );

    // working registers: accumulator, base, exponent
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_start) begin
            r_dest <= i_ctl.mul_sel;
        end
        if (i_ctl.load) begin
            r_acc <= WIDTH'(1);
            r_exp <= r_priv_exp;
        end else if (i_ctl.exp_shift) begin
            r_exp <= r_exp >> 1;
        end
        if (w_mul_done) begin
            case (r_dest) inside
                MUL_RED, MUL_SQR: r_base <= w_mul_prod;
                MUL_ACC:          r_acc  <= w_mul_prod;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_result <= w_mod_small ? '0 : DATA_W'(r_acc);
        end
    end

    assign o_status.mul_done = w_mul_done;
    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.exp_lsb  = r_exp[0];
    assign o_status.out_free = w_out_free;
    assign o_out_valid       = r_out_valid;
    assign o_result          = r_result;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_load |-> w_out_free)
        else $error("result loaded over an untaken transaction");

    a_no_start_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |-> !i_ctl.out_load && !i_ctl.exp_shift)
        else $error("load issued together with another command");

    a_load_starts_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |-> i_ctl.mul_start && (i_ctl.mul_sel == MUL_RED))
        else $error("load without base reduction");

endmodule

// ===== src/dhm_ctrl.sv =====
module dhm_ctrl
    import dhm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_ctl
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (i_status.mul_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.exp_zero) begin
                    n_state = ST_DONE;
                end else if (i_status.exp_lsb) begin
                    n_state = ST_MUL_ACC;
                end else begin
                    n_state = ST_MUL_SQR;
                end
            end
            ST_MUL_ACC: begin
                if (i_status.mul_done) begin
                    n_state = ST_MUL_SQR;
                end
            end
            ST_MUL_SQR: begin
                if (i_status.mul_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_ctl      = '0;
        o_ctl.mul_sel = MUL_RED;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.load      = 1'b1;
                    o_ctl.mul_start = 1'b1;
                    o_ctl.mul_sel   = MUL_RED;
                end
            end
            ST_CHECK: begin
                if (!i_status.exp_zero) begin
                    o_ctl.mul_start = 1'b1;
                    o_ctl.mul_sel   = i_status.exp_lsb ? MUL_ACC : MUL_SQR;
                end
            end
            ST_MUL_ACC: begin
                if (i_status.mul_done) begin
                    o_ctl.mul_start = 1'b1;
                    o_ctl.mul_sel   = MUL_SQR;
                end
            end
            ST_MUL_SQR: begin
                o_ctl.exp_shift = i_status.mul_done;
            end
            ST_DONE: begin
                o_ctl.out_load = i_status.out_free;
            end
            default: ;
        endcase
    end

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_REDUCE))
        else $error("accepted transaction did not start reduction");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.out_load |=> (r_state == ST_IDLE))
        else $error("controller did not return to idle after result");

    a_check_on_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && i_status.exp_zero) |-> !o_ctl.mul_start)
        else $error("multiply started with exhausted exponent");

endmodule

// ===== src/diffie_hellman_modexp_top.sv =====
// Diffie-Hellman modular exponentiation engine. Each transaction computes
// base^private_exponent mod modulus by right-to-left square-and-multiply and
// returns one result: cmd 0 uses the generator register (public key), cmd 1
// uses peer_value (shared secret). Only the low WIDTH bits of the modulus are
// used; a modulus below two gives 0 and a zero exponent gives 1. One item is
// processed at a time. Every modular product goes through a shared
// shift-and-add multiplier doing one add-and-reduce per cycle: a doubling
// and then a conditional add for each bit of the second operand, msb first,
// before it hands the product over. The base reduction takes one product,
// then each exponent bit up to the highest set bit costs a pass through the
// check state and a squaring, plus a multiply when the bit is set. A new
// request can be accepted in the same cycle that the result appears. The
// finished result sits in an output register, so it may wait for the
// consumer while a new request is accepted. Configuration must be written
// only while idle.
module diffie_hellman_modexp_top
    import dhm_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cmd,
    input  logic [DATA_W-1:0]    i_peer_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DATA_W-1:0]    o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    t_dp_cmd    w_ctl;
    t_dp_status w_status;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    dhm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_ctl      (w_ctl)
    );

    dhm_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_status     (w_status),
        .i_cmd        (i_cmd),
        .i_peer_value (i_peer_value),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_result     (o_result)
    );

endmodule
